FILE: hdl/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned MAX_PATTERN     = 8;
  localparam int unsigned MAX_REPLACEMENT = 8;
  localparam int unsigned WORD_BYTES      = 8;
  localparam int unsigned WORD_W          = 8 * WORD_BYTES;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned IDX_W           = $clog2(WORD_BYTES);
  localparam int unsigned JQ_DEPTH        = 4;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES,
    CFG_PATTERN_LENGTH,
    CFG_REPLACEMENT_BYTES,
    CFG_REPLACEMENT_LENGTH
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_content;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
    logic       last_of_run;
  } out_item_t;

  // effective configuration, lengths already clamped
  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [CNT_W-1:0]  plen;
    logic [WORD_W-1:0] repl;
    logic [CNT_W-1:0]  rlen;
  } cfg_t;

  // one queued job: emit the first count bytes of data; count zero with fin
  // set stands for a bare end marker
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              fin;
  } job_t;

endpackage

FILE: hdl/stream_find_and_replace_core.sv
// Channel   Dir  Handshake          Beat
// -------   ---  ---------          ----
// input     in   push / full        in_item_i  (data_byte, byte_present, end_of_content)
// result    out  empty / pop        out_item_o (out_byte, out_valid, out_end, last_of_run)
// config    in   cfg_we_i           cfg_idx_i, cfg_data_i (no wait, no read-back)
//
// An input beat is taken every cycle while the job queue has room; the front
// classifies the whole window in that cycle.
// Results leave at one beat per cycle from the back while they are popped, so
// an input that causes r results occupies the back until its last one is
// loaded; a result passes through the job queue, then the output register.
// Reset clears config, held count, queue pointers and output valid; no
// clearing pass. Either side may stall freely, the four-deep job queue and
// the output register decouple them.
module stream_find_and_replace_core import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  logic [WORD_W-1:0] pat_q, repl_q;
  logic [CNT_W-1:0]  plen_q, rlen_q;
  cfg_t              cfg;
  logic              accept, held_empty;
  job_t              fr_job, bk_job;
  logic              fr_push, q_full, q_empty, bk_pop;

  // register file; pattern writes are dropped while bytes are held, so the
  // held window stays a prefix of the pattern in force
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= '0;
      repl_q <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_BYTES: begin
          if (held_empty) pat_q <= cfg_data_i;
        end
        CFG_PATTERN_LENGTH: begin
          if (held_empty) plen_q <= cfg_data_i[CNT_W-1:0];
        end
        CFG_REPLACEMENT_BYTES: begin
          repl_q <= cfg_data_i;
        end
        CFG_REPLACEMENT_LENGTH: begin
          rlen_q <= cfg_data_i[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // oversized lengths act as the maximum
  always_comb begin
    cfg.pattern = pat_q;
    cfg.repl    = repl_q;
    cfg.plen    = (plen_q > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : plen_q;
    cfg.rlen    = (rlen_q > CNT_W'(MAX_REPLACEMENT)) ? CNT_W'(MAX_REPLACEMENT) : rlen_q;
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .job_o        (fr_job),
    .job_push_o   (fr_push),
    .held_empty_o (held_empty)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .job_i   (fr_job),
    .full_o  (q_full),
    .pop_i   (bk_pop),
    .job_o   (bk_job),
    .empty_o (q_empty)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (bk_job),
    .job_empty_i (q_empty),
    .job_pop_o   (bk_pop),
    .out_o       (out_item_o),
    .out_empty_o (empty),
    .pop_i       (pop)
  );

endmodule

FILE: hdl/sfr_front.sv
module sfr_front import sfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output job_t     job_o,
  output logic     job_push_o,
  output logic     held_empty_o
);

  logic [7:0]             held_q [MAX_PATTERN];
  logic [7:0]             held_d [MAX_PATTERN];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [7:0]             win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match;
  logic [CNT_W-1:0]       n, shift, remain;
  logic [WORD_W-1:0]      win_word;
  logic                   replace;

  // window = held bytes with the new byte appended
  always_comb begin
    win_word = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win[j] = (CNT_W'(j) == cnt_q) ? item_i.data_byte : held_q[j];
      win_word[8*j +: 8] = win[j];
    end
  end

  // all byte-vs-pattern compares in parallel, then a prefix check per offset
  always_comb begin
    n = cnt_q + CNT_W'(1);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        eq[j][i] = (win[j] == cfg_i.pattern[8*i +: 8]);
      end
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      match[k] = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if ((k + i) < MAX_PATTERN && (k + i) < int'(n)) begin
          match[k] = match[k] & eq[(k + i) % MAX_PATTERN][i];
        end
      end
    end
    shift = n;
    for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
      if (CNT_W'(k) < n && match[k]) begin
        shift = CNT_W'(k);
      end
    end
    remain  = n - shift;
    replace = (remain == cfg_i.plen);
  end

  always_comb begin
    job_o.data  = win_word;
    job_o.count = '0;
    job_o.fin   = item_i.end_of_content;
    cnt_d       = cnt_q;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      held_d[j] = held_q[j];
    end
    if (item_i.byte_present) begin
      if (cfg_i.plen == '0) begin
        job_o.data  = {{(WORD_W-8){1'b0}}, item_i.data_byte};
        job_o.count = CNT_W'(1);
      end else if (replace) begin
        job_o.data  = cfg_i.repl;
        job_o.count = cfg_i.rlen;
        cnt_d       = '0;
      end else begin
        job_o.count = item_i.end_of_content ? n : shift;
        cnt_d       = item_i.end_of_content ? '0 : remain;
        for (int j = 0; j < MAX_PATTERN; j++) begin
          held_d[j] = '0;
          for (int s = 0; s < MAX_PATTERN; s++) begin
            if (shift == CNT_W'(s) && (j + s) < MAX_PATTERN) begin
              held_d[j] = win[(j + s) % MAX_PATTERN];
            end
          end
        end
      end
    end else if (item_i.end_of_content) begin
      job_o.count = cnt_q;
      cnt_d       = '0;
    end
  end

  assign job_push_o   = accept_i && (job_o.count != '0 || job_o.fin);
  assign held_empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

FILE: hdl/sfr_queue.sv
module sfr_queue import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(JQ_DEPTH);

  job_t             mem_q [JQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == (PTR_W+1)'(JQ_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: hdl/sfr_back.sv
module sfr_back import sfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_pop_o,
  output out_item_t out_o,
  output logic      out_empty_o,
  input  logic      pop_i
);

  logic [CNT_W-1:0] idx_q;
  logic             vld_q;
  out_item_t        out_q, res;
  logic             load, is_last;

  assign load    = !job_empty_i && (!vld_q || pop_i);
  assign is_last = (job_i.count == '0) || (idx_q == job_i.count - CNT_W'(1));

  always_comb begin
    res.out_byte    = '0;
    res.out_valid   = (job_i.count != '0);
    res.out_end     = job_i.fin && is_last;
    res.last_of_run = is_last;
    if (job_i.count != '0) begin
      res.out_byte = job_i.data[{idx_q[IDX_W-1:0], 3'b000} +: 8];
    end
  end

  assign job_pop_o   = load && is_last;
  assign out_o       = out_q;
  assign out_empty_o = !vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else if (load) begin
      idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
      vld_q <= 1'b1;
    end else if (pop_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

endmodule

FILE: hdl/sfr_checker.sv
module sfr_checker import sfr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // end of content always closes the run of its input
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.out_end) |-> out_item_o.last_of_run)
    else $error("out_end without last_of_run");

  // a bare marker only ever stands for an empty end of content
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.out_valid) |->
      (out_item_o.out_byte == 8'd0 && out_item_o.out_end && out_item_o.last_of_run))
    else $error("malformed bare end marker");

  // a waiting result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (.*);
